// ===== rtl/sawarq_pkg.sv =====
// Shared types and codes of the stop-and-wait ARQ sender.
// Used by the controller, the datapath, the top level and the checker.
package sawarq_pkg;

    // Input item kinds (tuser on the slave side)
    localparam logic [2:0] KIND_PAYLOAD  = 3'd0;
    localparam logic [2:0] KIND_EMPTY    = 3'd1;
    localparam logic [2:0] KIND_ACK_BYTE = 3'd2;
    localparam logic [2:0] KIND_ACK_HDR  = 3'd3;
    localparam logic [2:0] KIND_TIMEOUT  = 3'd4;

    // Result kinds (tuser on the master side)
    localparam logic [1:0] OUT_HEADER    = 2'd0;
    localparam logic [1:0] OUT_BYTE      = 2'd1;
    localparam logic [1:0] OUT_DELIVERED = 2'd2;
    localparam logic [1:0] OUT_GAVE_UP   = 2'd3;

    localparam logic [3:0] RETRY_LIMIT_RESET = 4'd3;
    localparam logic [3:0] RETRY_SAT         = 4'd15;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_HDR,
        ST_RD,
        ST_BYTE,
        ST_FIN_OK,
        ST_FIN_GIVE
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic gather;     // store payload byte, bump length
        logic empty;      // drop gathered bytes
        logic start;      // form checksum, enter waiting
        logic ack_byte;   // fold ACK byte into ACK XOR
        logic ack_hdr;    // clear ACK XOR
        logic timeout;    // count a retry
        logic rd;         // read stored byte at index
        logic idx_clr;
        logic idx_inc;
        logic load_hdr;   // load header result
        logic load_byte;  // load payload byte result
        logic load_fin;   // load delivered / gave-up result
        logic fin_give;   // final result is gave-up
        logic finish;     // toggle sequence, empty buffer, leave waiting
    } cmd_t;

    // Status from datapath to controller
    typedef struct packed {
        logic waiting;
        logic full_next;
        logic ack_ok;
        logic retry_over;
        logic len_zero;
        logic idx_last;
        logic out_free;
    } sts_t;

endpackage

// ===== rtl/sawarq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sawarq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 10
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, held while no read is requested
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== rtl/sawarq_ctrl.sv =====
// Controller state machine of the stop-and-wait ARQ sender.
// Depends on sawarq_pkg for states, codes, command and status types.
module sawarq_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         in_kind,
    input  logic               in_last,
    input  sawarq_pkg::sts_t   sts,
    output sawarq_pkg::cmd_t   cmd
);

    sawarq_pkg::state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sawarq_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        case (state_reg)
            sawarq_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    if (!sts.waiting)
                    begin
                        if (in_kind == sawarq_pkg::KIND_PAYLOAD)
                        begin
                            cmd.gather = 1'b1;
                            if (in_last || sts.full_next)
                            begin
                                state_next = sawarq_pkg::ST_START;
                            end
                        end
                        else if (in_kind == sawarq_pkg::KIND_EMPTY)
                        begin
                            cmd.empty  = 1'b1;
                            state_next = sawarq_pkg::ST_START;
                        end
                    end
                    else
                    begin
                        if (in_kind == sawarq_pkg::KIND_ACK_BYTE)
                        begin
                            cmd.ack_byte = 1'b1;
                        end
                        else if (in_kind == sawarq_pkg::KIND_ACK_HDR)
                        begin
                            cmd.ack_hdr = 1'b1;
                            state_next  = sts.ack_ok ? sawarq_pkg::ST_FIN_OK
                                                     : sawarq_pkg::ST_HDR;
                        end
                        else if (in_kind == sawarq_pkg::KIND_TIMEOUT)
                        begin
                            cmd.timeout = 1'b1;
                            state_next  = sts.retry_over ? sawarq_pkg::ST_FIN_GIVE
                                                         : sawarq_pkg::ST_HDR;
                        end
                    end
                end
            end
            sawarq_pkg::ST_START:
            begin
                cmd.start  = 1'b1;
                state_next = sawarq_pkg::ST_HDR;
            end
            sawarq_pkg::ST_HDR:
            begin
                if (sts.out_free)
                begin
                    cmd.load_hdr = 1'b1;
                    cmd.idx_clr  = 1'b1;
                    state_next   = sts.len_zero ? sawarq_pkg::ST_IDLE
                                                : sawarq_pkg::ST_RD;
                end
            end
            sawarq_pkg::ST_RD:
            begin
                cmd.rd     = 1'b1;
                state_next = sawarq_pkg::ST_BYTE;
            end
            sawarq_pkg::ST_BYTE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_byte = 1'b1;
                    cmd.idx_inc   = 1'b1;
                    state_next    = sts.idx_last ? sawarq_pkg::ST_IDLE
                                                 : sawarq_pkg::ST_RD;
                end
            end
            sawarq_pkg::ST_FIN_OK,
            sawarq_pkg::ST_FIN_GIVE:
            begin
                if (sts.out_free)
                begin
                    cmd.load_fin = 1'b1;
                    cmd.fin_give = (state_reg == sawarq_pkg::ST_FIN_GIVE);
                    cmd.finish   = 1'b1;
                    state_next   = sawarq_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sawarq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/sawarq_dp.sv =====
// Datapath of the stop-and-wait ARQ sender: protocol state, checksums,
// payload buffer and result register. Depends on sawarq_pkg and sawarq_ram.
module sawarq_dp #(
    parameter int MAX_PAYLOAD = 10
) (
    input  logic              clk,
    input  logic              rst_n,
    input  sawarq_pkg::cmd_t  cmd,
    output sawarq_pkg::sts_t  sts,
    input  logic              cfg_valid,
    input  logic [3:0]        cfg_data,
    input  logic [7:0]        data_byte,
    input  logic [7:0]        ack_seq,
    input  logic [7:0]        ack_len,
    input  logic [7:0]        ack_cksum,
    output logic              out_valid,
    input  logic              out_ready,
    output logic [1:0]        out_kind,
    output logic [7:0]        out_byte,
    output logic              out_seq,
    output logic [3:0]        out_len,
    output logic [7:0]        out_cksum,
    output logic              out_end
);

    localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
    localparam int ADDR_W = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

    logic              seq_reg, seq_next;
    logic              waiting_reg, waiting_next;
    logic [3:0]        retry_reg, retry_next;
    logic [3:0]        limit_reg, limit_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [7:0]        cksum_reg, cksum_next;
    logic [7:0]        ackxor_reg, ackxor_next;
    logic [7:0]        payxor_reg, payxor_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic              ovalid_reg, ovalid_next;

    logic [1:0]        okind_reg;
    logic [7:0]        obyte_reg;
    logic              oseq_reg;
    logic [3:0]        olen_reg;
    logic [7:0]        ocksum_reg;
    logic              oend_reg;

    logic [3:0]        retry_inc;
    logic [7:0]        rd_byte;
    logic              out_free;

    // Payload buffer
    sawarq_ram #(
        .WIDTH (8),
        .DEPTH (MAX_PAYLOAD)
    ) u_ram (
        .clk   (clk),
        .we    (cmd.gather),
        .waddr (ADDR_W'(len_reg)),
        .wdata (data_byte),
        .re    (cmd.rd),
        .raddr (idx_reg),
        .rdata (rd_byte)
    );

    // Status towards the controller
    assign retry_inc = (retry_reg == sawarq_pkg::RETRY_SAT) ? retry_reg : retry_reg + 4'd1;
    assign out_free  = !ovalid_reg || out_ready;

    always_comb
    begin
        sts.waiting    = waiting_reg;
        sts.full_next  = (len_reg == LEN_W'(MAX_PAYLOAD - 1));
        sts.ack_ok     = (ack_cksum == (ack_seq ^ ack_len ^ ackxor_reg))
                         && (ack_seq == {7'd0, seq_reg});
        sts.retry_over = (retry_inc >= limit_reg);
        sts.len_zero   = (len_reg == '0);
        sts.idx_last   = ((LEN_W'(idx_reg) + LEN_W'(1)) == len_reg);
        sts.out_free   = out_free;
    end

    // Protocol state updates
    always_comb
    begin
        seq_next     = seq_reg;
        waiting_next = waiting_reg;
        retry_next   = retry_reg;
        limit_next   = limit_reg;
        len_next     = len_reg;
        cksum_next   = cksum_reg;
        ackxor_next  = ackxor_reg;
        payxor_next  = payxor_reg;
        idx_next     = idx_reg;
        if (cfg_valid)
        begin
            limit_next = cfg_data;
        end
        if (cmd.gather)
        begin
            len_next    = len_reg + LEN_W'(1);
            payxor_next = payxor_reg ^ data_byte;
        end
        if (cmd.empty)
        begin
            len_next    = '0;
            payxor_next = '0;
        end
        if (cmd.start)
        begin
            cksum_next   = {7'd0, seq_reg} ^ 8'(len_reg) ^ payxor_reg;
            waiting_next = 1'b1;
            retry_next   = '0;
            ackxor_next  = '0;
        end
        if (cmd.ack_byte)
        begin
            ackxor_next = ackxor_reg ^ data_byte;
        end
        if (cmd.ack_hdr)
        begin
            ackxor_next = '0;
        end
        if (cmd.timeout)
        begin
            retry_next = retry_inc;
        end
        if (cmd.idx_clr)
        begin
            idx_next = '0;
        end
        if (cmd.idx_inc)
        begin
            idx_next = idx_reg + ADDR_W'(1);
        end
        if (cmd.finish)
        begin
            waiting_next = 1'b0;
            retry_next   = '0;
            seq_next     = !seq_reg;
            len_next     = '0;
            payxor_next  = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg     <= 1'b0;
            waiting_reg <= 1'b0;
            retry_reg   <= '0;
            limit_reg   <= sawarq_pkg::RETRY_LIMIT_RESET;
            len_reg     <= '0;
            cksum_reg   <= '0;
            ackxor_reg  <= '0;
            payxor_reg  <= '0;
            idx_reg     <= '0;
        end
        else
        begin
            seq_reg     <= seq_next;
            waiting_reg <= waiting_next;
            retry_reg   <= retry_next;
            limit_reg   <= limit_next;
            len_reg     <= len_next;
            cksum_reg   <= cksum_next;
            ackxor_reg  <= ackxor_next;
            payxor_reg  <= payxor_next;
            idx_reg     <= idx_next;
        end
    end

    // Result register: set on load, drop once taken
    always_comb
    begin
        ovalid_next = ovalid_reg;
        if (cmd.load_hdr || cmd.load_byte || cmd.load_fin)
        begin
            ovalid_next = 1'b1;
        end
        else if (out_ready)
        begin
            ovalid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else
        begin
            ovalid_reg <= ovalid_next;
        end
    end

    // Result payload, taken from state before this cycle's updates
    always_ff @(posedge clk)
    begin
        if (cmd.load_hdr || cmd.load_byte || cmd.load_fin)
        begin
            oseq_reg   <= seq_reg;
            olen_reg   <= 4'(len_reg);
            ocksum_reg <= cksum_reg;
            if (cmd.load_byte)
            begin
                okind_reg <= sawarq_pkg::OUT_BYTE;
                obyte_reg <= rd_byte;
                oend_reg  <= sts.idx_last;
            end
            else if (cmd.load_fin)
            begin
                okind_reg <= cmd.fin_give ? sawarq_pkg::OUT_GAVE_UP
                                          : sawarq_pkg::OUT_DELIVERED;
                obyte_reg <= '0;
                oend_reg  <= 1'b1;
            end
            else
            begin
                okind_reg <= sawarq_pkg::OUT_HEADER;
                obyte_reg <= '0;
                oend_reg  <= sts.len_zero;
            end
        end
    end

    assign out_valid = ovalid_reg;
    assign out_kind  = okind_reg;
    assign out_byte  = obyte_reg;
    assign out_seq   = oseq_reg;
    assign out_len   = olen_reg;
    assign out_cksum = ocksum_reg;
    assign out_end   = oend_reg;

endmodule

// ===== rtl/stop_and_wait_arq_sender_unit.sv =====
// Top level of the alternating-bit stop-and-wait ARQ sender.
// Depends on sawarq_pkg, sawarq_ctrl, sawarq_dp (and sawarq_ram below it).
//
//  Channel  | Direction | tdata (low bit up)                     | tuser    | tlast
//  s_axis   | in        | data_byte, ack_seq, ack_len, ack_cksum | kind     | last
//  m_axis   | out       | out_byte, out_seq, out_len, out_cksum  | out_kind | out_end
//  cfg      | in        | cfg_data = retry_limit                 | -        | -
//
// A send passes through the accepting state, a checksum state and a header
// state, then through a buffer RAM read state and a result load state for each
// stored byte; a resend skips the checksum state, and a delivered or gave-up
// report passes through the accepting state and then a report state.
// Input is taken only in the idle state; a waiting result does not block it.
// Output stalls hold the result register and the sequencer in place.
// Reset is asynchronous, active low; the buffer itself needs no clearing.
module stop_and_wait_arq_sender_unit #(
    parameter int MAX_PAYLOAD = 10
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // data_byte, ack_seq, ack_len, ack_cksum
    input  logic [2:0]  s_axis_tuser,   // kind
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // out_byte, out_seq, out_len, out_cksum, zero pad
    output logic [1:0]  m_axis_tuser,   // out_kind
    output logic        m_axis_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data        // retry_limit
);

    sawarq_pkg::cmd_t cmd;
    sawarq_pkg::sts_t sts;

    logic [7:0] out_byte;
    logic       out_seq;
    logic [3:0] out_len;
    logic [7:0] out_cksum;

    assign cfg_ready = 1'b1;

    sawarq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_kind  (s_axis_tuser),
        .in_last  (s_axis_tlast),
        .sts      (sts),
        .cmd      (cmd)
    );

    sawarq_dp #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .sts       (sts),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .data_byte (s_axis_tdata[7:0]),
        .ack_seq   (s_axis_tdata[15:8]),
        .ack_len   (s_axis_tdata[23:16]),
        .ack_cksum (s_axis_tdata[31:24]),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_kind  (m_axis_tuser),
        .out_byte  (out_byte),
        .out_seq   (out_seq),
        .out_len   (out_len),
        .out_cksum (out_cksum),
        .out_end   (m_axis_tlast)
    );

    // Pack result fields
    assign m_axis_tdata = {3'd0, out_cksum, out_len, out_seq, out_byte};

endmodule

// ===== rtl/sawarq_chk.sv =====
// Port-level checker for the stop-and-wait ARQ sender, bound to the top level.
// Depends on sawarq_pkg for result kind codes.
module sawarq_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic [1:0]  m_axis_tuser,
    input logic        m_axis_tlast
);

    // Hold a stalled result
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled result changed");

    // Delivery and give-up reports close the request and carry no byte
    a_fin_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == sawarq_pkg::OUT_DELIVERED
            || m_axis_tuser == sawarq_pkg::OUT_GAVE_UP)
        |-> m_axis_tlast && (m_axis_tdata[7:0] == 8'd0))
        else $error("final report malformed");

    // A payload byte belongs to a packet of non-zero length
    a_byte_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == sawarq_pkg::OUT_BYTE)
        |-> (m_axis_tdata[12:9] != 4'd0))
        else $error("payload byte in empty packet");

    // A header of an empty packet is the last result of its request
    a_empty_hdr: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == sawarq_pkg::OUT_HEADER)
            && (m_axis_tdata[12:9] == 4'd0)
        |-> m_axis_tlast && (m_axis_tdata[7:0] == 8'd0))
        else $error("empty header not last");

endmodule

bind stop_and_wait_arq_sender_unit sawarq_chk u_sawarq_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ===== test/stop_and_wait_arq_sender_unit_tb.sv =====
// Self-checking testbench of the stop-and-wait ARQ sender top level.
// Needs sawarq_pkg and stop_and_wait_arq_sender_unit; predicts every result
// in step with accepted requests and checks each one field by field.
module stop_and_wait_arq_sender_unit_tb;

    localparam int         BUF_BYTES     = 10;
    localparam int         SETTLE_CYCLES = 2 + 2 * BUF_BYTES + 8;
    localparam int         DRAIN_LIMIT   = 20000;
    localparam logic [2:0] KIND_SPARE_A  = 3'd5;
    localparam logic [2:0] KIND_SPARE_B  = 3'd6;
    localparam logic [2:0] KIND_SPARE_C  = 3'd7;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] pay;
        logic       seq;
        logic [3:0] len;
        logic [7:0] cksum;
        logic       fin;
    } arq_result_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic [2:0]  s_axis_tuser = '0;
    logic        s_axis_tlast = 1'b0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;
    logic        m_axis_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [3:0]  cfg_data = '0;

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int mismatches    = 0;

    // Sender model state
    arq_result_t sender_events[$];
    logic        seq_m;
    logic        waiting_m;
    int          retries_m;
    logic [7:0]  store_m[BUF_BYTES];
    int          len_m;
    logic [7:0]  tx_ck_m;
    logic [7:0]  ack_xor_m;
    logic [3:0]  retry_limit_m = sawarq_pkg::RETRY_LIMIT_RESET;

    stop_and_wait_arq_sender_unit #(
        .MAX_PAYLOAD (BUF_BYTES)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Stall the result side at random
    always @(posedge clk)
    begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // ---------------------------------------------------------------- model

    function automatic void push_result(input logic [1:0] k, input logic [7:0] b);
        arq_result_t r;
        r.kind  = k;
        r.pay   = b;
        r.seq   = seq_m;
        r.len   = len_m[3:0];
        r.cksum = tx_ck_m;
        r.fin   = 1'b0;
        sender_events.push_back(r);
    endfunction

    function automatic void emit_packet();
        push_result(sawarq_pkg::OUT_HEADER, 8'h00);
        for (int i = 0; i < len_m; i++)
            push_result(sawarq_pkg::OUT_BYTE, store_m[i]);
    endfunction

    function automatic void start_send();
        logic [7:0] c;
        c = {7'd0, seq_m} ^ len_m[7:0];
        for (int i = 0; i < len_m; i++)
            c = c ^ store_m[i];
        tx_ck_m   = c;
        waiting_m = 1'b1;
        retries_m = 0;
        ack_xor_m = 8'h00;
        emit_packet();
    endfunction

    function automatic void close_packet(input logic [1:0] k);
        push_result(k, 8'h00);
        waiting_m = 1'b0;
        retries_m = 0;
        seq_m     = ~seq_m;
        len_m     = 0;
    endfunction

    // Work out the results of one accepted request
    function automatic void arq_step(input logic [2:0] kind, input logic [7:0] data,
                                     input logic last, input logic [7:0] aseq,
                                     input logic [7:0] alen, input logic [7:0] ack);
        int          n0;
        arq_result_t r;
        n0 = sender_events.size();
        if (!waiting_m)
        begin
            if (kind == sawarq_pkg::KIND_PAYLOAD)
            begin
                if (len_m < BUF_BYTES)
                begin
                    store_m[len_m] = data;
                    len_m++;
                end
                if (last || len_m >= BUF_BYTES)
                    start_send();
            end
            else if (kind == sawarq_pkg::KIND_EMPTY)
            begin
                len_m = 0;
                start_send();
            end
        end
        else
        begin
            if (kind == sawarq_pkg::KIND_ACK_BYTE)
                ack_xor_m = ack_xor_m ^ data;
            else if (kind == sawarq_pkg::KIND_ACK_HDR)
            begin
                if (ack != (aseq ^ alen ^ ack_xor_m) || aseq != {7'd0, seq_m})
                    emit_packet();
                else
                    close_packet(sawarq_pkg::OUT_DELIVERED);
                ack_xor_m = 8'h00;
            end
            else if (kind == sawarq_pkg::KIND_TIMEOUT)
            begin
                if (retries_m < sawarq_pkg::RETRY_SAT)
                    retries_m++;
                if (retries_m >= retry_limit_m)
                    close_packet(sawarq_pkg::OUT_GAVE_UP);
                else
                    emit_packet();
            end
        end
        // Mark the final result of this request
        if (sender_events.size() > n0)
        begin
            r = sender_events.pop_back();
            r.fin = 1'b1;
            sender_events.push_back(r);
        end
    endfunction

    // ---------------------------------------------------------------- checking

    function automatic void check_field(input string name, input int want, input int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : check_results
        arq_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (sender_events.size() == 0)
            begin
                $error("out_kind: expected no result, got %0d", m_axis_tuser);
                mismatches++;
            end
            else
            begin
                want = sender_events.pop_front();
                check_field("out_kind", want.kind, m_axis_tuser);
                check_field("out_byte", want.pay, m_axis_tdata[7:0]);
                check_field("out_seq", want.seq, m_axis_tdata[8]);
                check_field("out_len", want.len, m_axis_tdata[12:9]);
                check_field("out_cksum", want.cksum, m_axis_tdata[20:13]);
                check_field("out_end", want.fin, m_axis_tlast);
            end
        end
    end

    // ---------------------------------------------------------------- drivers

    // Offer one request, hold it until taken, then predict its results
    task automatic send_item(input logic [2:0] kind, input logic [7:0] data, input logic last,
                             input logic [7:0] aseq, input logic [7:0] alen,
                             input logic [7:0] ack);
        if ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(4, 1)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tlast  <= last;
        s_axis_tdata  <= {ack, alen, aseq, data};
        do @(posedge clk); while (!s_axis_tready);
        arq_step(kind, data, last, aseq, alen, ack);
    endtask

    // Wait for every expected result, then let the sequencer settle
    task automatic drain();
        int w;
        w = 0;
        while (sender_events.size() != 0 && w < DRAIN_LIMIT)
        begin
            @(posedge clk);
            w++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_retry_limit(input logic [3:0] lim);
        s_axis_tvalid <= 1'b0;
        drain();
        cfg_valid <= 1'b1;
        cfg_data  <= lim;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        retry_limit_m = lim;
    endtask

    // Payload request with random filler in the ACK fields
    task automatic send_byte(input logic [7:0] data, input logic last);
        send_item(sawarq_pkg::KIND_PAYLOAD, data, last, 8'($urandom), 8'($urandom),
                  8'($urandom));
    endtask

    task automatic send_ctrl(input logic [2:0] kind);
        send_item(kind, 8'($urandom), 1'($urandom), 8'($urandom), 8'($urandom),
                  8'($urandom));
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_directed();
        // Drop ACK traffic and spare kinds while idle
        send_ctrl(sawarq_pkg::KIND_TIMEOUT);
        send_ctrl(sawarq_pkg::KIND_ACK_HDR);
        send_ctrl(sawarq_pkg::KIND_ACK_BYTE);
        send_ctrl(KIND_SPARE_C);
        // Two-byte packet with extreme bytes
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        // Drop new payload and spare kinds while waiting
        send_ctrl(sawarq_pkg::KIND_PAYLOAD);
        send_ctrl(sawarq_pkg::KIND_EMPTY);
        send_ctrl(KIND_SPARE_A);
        // Timeout resends; wrong sequence and bad checksum resend uncounted; third timeout gives up
        send_ctrl(sawarq_pkg::KIND_TIMEOUT);
        send_item(sawarq_pkg::KIND_ACK_HDR, 8'($urandom), 1'b0, 8'h01, 8'h02, 8'h03);
        send_item(sawarq_pkg::KIND_ACK_BYTE, 8'hA5, 1'b0, 8'($urandom), 8'($urandom),
                  8'($urandom));
        send_item(sawarq_pkg::KIND_ACK_HDR, 8'($urandom), 1'b0, 8'h00, 8'h02, 8'h02);
        send_ctrl(sawarq_pkg::KIND_TIMEOUT);
        send_ctrl(sawarq_pkg::KIND_TIMEOUT);
        // Empty request with bytes pending discards them
        send_byte(8'h12, 1'b0);
        send_byte(8'h34, 1'b0);
        send_ctrl(sawarq_pkg::KIND_EMPTY);
        send_item(sawarq_pkg::KIND_ACK_BYTE, 8'h5A, 1'b0, 8'($urandom), 8'($urandom),
                  8'($urandom));
        send_item(sawarq_pkg::KIND_ACK_BYTE, 8'hC3, 1'b0, 8'($urandom), 8'($urandom),
                  8'($urandom));
        send_item(sawarq_pkg::KIND_ACK_HDR, 8'($urandom), 1'b0, 8'h01, 8'hFF,
                  8'h01 ^ 8'hFF ^ 8'h5A ^ 8'hC3);
        // Full buffer sends without last
        for (int i = 0; i < BUF_BYTES; i++)
            send_byte((i % 2) ? 8'hFF - 8'(i) : 8'(1 << (i % 8)), 1'b0);
        send_item(sawarq_pkg::KIND_ACK_HDR, 8'($urandom), 1'b0, 8'h00, 8'd10, 8'd10);
        send_ctrl(KIND_SPARE_B);
    endtask

    task automatic test_retry_limits();
        // Limit of one: first timeout gives up
        set_retry_limit(4'd1);
        send_ctrl(sawarq_pkg::KIND_EMPTY);
        send_ctrl(sawarq_pkg::KIND_TIMEOUT);
        // Highest limit: fourteen resends, then give up
        set_retry_limit(4'd15);
        send_ctrl(sawarq_pkg::KIND_EMPTY);
        for (int i = 0; i < 15; i++)
            send_ctrl(sawarq_pkg::KIND_TIMEOUT);
    endtask

    task automatic test_random_traffic(input int src_pct, input int sink_pct, input int n_items);
        int         done;
        int         r;
        int         nb;
        logic [7:0] x;
        logic [7:0] a_seq;
        logic [7:0] a_len;
        logic [7:0] a_ck;
        src_idle_pct  = src_pct;
        sink_idle_pct = sink_pct;
        done = 0;
        while (done < n_items)
        begin
            r = $urandom_range(99);
            if (!waiting_m)
            begin
                if (r < 8)
                begin
                    // Noise that the idle sender drops
                    send_ctrl(3'($urandom_range(sawarq_pkg::KIND_ACK_BYTE, KIND_SPARE_C)));
                end
                else if (r < 20)
                begin
                    nb = $urandom_range(2);
                    for (int i = 0; i < nb; i++)
                        send_byte(8'($urandom), 1'b0);
                    send_ctrl(sawarq_pkg::KIND_EMPTY);
                    done += nb + 1;
                end
                else
                begin
                    nb = ($urandom_range(9) == 0) ? BUF_BYTES : $urandom_range(4, 1);
                    for (int i = 0; i < nb; i++)
                        send_byte(8'($urandom), (i == nb - 1) ? 1'($urandom) : 1'b0);
                    if (waiting_m == 1'b0)
                    begin
                        send_byte(8'($urandom), 1'b1);
                        done++;
                    end
                    done += nb;
                end
            end
            else if (r < 30)
            begin
                send_ctrl(sawarq_pkg::KIND_TIMEOUT);
                done++;
            end
            else if (r < 85)
            begin
                // ACK with random body; some corrupted in sequence or checksum
                nb = $urandom_range(3);
                x  = 8'h00;
                for (int i = 0; i < nb; i++)
                begin
                    a_ck = 8'($urandom);
                    x    = x ^ a_ck;
                    send_item(sawarq_pkg::KIND_ACK_BYTE, a_ck, 1'($urandom), 8'($urandom),
                              8'($urandom), 8'($urandom));
                end
                a_seq = {7'd0, seq_m};
                a_len = 8'($urandom);
                a_ck  = a_seq ^ a_len ^ x;
                if (r >= 70)
                begin
                    if ($urandom_range(1))
                        a_seq = 8'($urandom);
                    else
                        a_ck = a_ck ^ 8'($urandom_range(255, 1));
                end
                send_item(sawarq_pkg::KIND_ACK_HDR, 8'($urandom), 1'($urandom), a_seq, a_len,
                          a_ck);
                done += nb + 1;
            end
            else
            begin
                // Noise that the waiting sender drops
                case ($urandom_range(2))
                    0: send_ctrl(sawarq_pkg::KIND_PAYLOAD);
                    1: send_ctrl(sawarq_pkg::KIND_EMPTY);
                    default: send_ctrl(3'($urandom_range(KIND_SPARE_A, KIND_SPARE_C)));
                endcase
            end
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial
    begin
        seq_m     = 1'b0;
        waiting_m = 1'b0;
        retries_m = 0;
        len_m     = 0;
        tx_ck_m   = 8'h00;
        ack_xor_m = 8'h00;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        src_idle_pct  = 34;
        sink_idle_pct = 75;
        test_directed();
        test_retry_limits();
        set_retry_limit(4'($urandom_range(5, 2)));
        test_random_traffic(34, 75, 18);
        set_retry_limit(sawarq_pkg::RETRY_LIMIT_RESET);
        test_random_traffic(75, 34, 18);
        set_retry_limit(4'($urandom_range(14, 6)));
        test_random_traffic(0, 0, 16);

        s_axis_tvalid <= 1'b0;
        drain();
        if (sender_events.size() != 0)
        begin
            $error("out_kind: %0d expected results never arrived", sender_events.size());
            mismatches++;
        end
        if (mismatches == 0)
            $display("stop_and_wait_arq_sender_unit_tb: clean");
        else
            $display("stop_and_wait_arq_sender_unit_tb: errors");
        $finish;
    end

    // Stop a hung run
    initial
    begin
        #5000000;
        $display("stop_and_wait_arq_sender_unit_tb: errors");
        $finish;
    end

endmodule
